FILE: hw/rtl/lst_pkg.sv
package lst_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_SESSION_SLOTS = 8;
    localparam int DEF_MIN_FRAME_LEN = 10;

    // Field widths
    localparam int TIME_W = 48;
    localparam int CNT_W  = 32;
    localparam int KEY_W  = 48;
    localparam int CFG_W  = 32;

    localparam logic [7:0]       START_MARK     = 8'hFD;
    localparam logic [CFG_W-1:0] HB_TIMEOUT_RST = 32'd5000;

    // Decoder outcome codes that admit a frame
    localparam logic [1:0] KIND_HEARTBEAT = 2'd1;
    localparam logic [1:0] KIND_OTHER     = 2'd2;

    typedef enum logic [1:0] {
        OP_INGEST    = 2'd0,
        OP_TICK      = 2'd1,
        OP_RECONNECT = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        SEQ_NONE     = 3'd0,
        SEQ_FIRST    = 3'd1,
        SEQ_IN_ORDER = 3'd2,
        SEQ_GAP      = 3'd3,
        SEQ_DUP      = 3'd4
    } t_seq_class;

    typedef enum logic [2:0] {
        LINK_UNKNOWN    = 3'd0,
        LINK_HEALTHY    = 3'd1,
        LINK_DEGRADED   = 3'd2,
        LINK_LOST       = 3'd3,
        LINK_RECOVERING = 3'd4
    } t_link;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

    // One session slot as stored in the state memory
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              seq_started;
        logic [7:0]        seq_last;
        logic [CNT_W-1:0]  cnt_rcv;
        logic [CNT_W-1:0]  cnt_lost;
        logic [CNT_W-1:0]  cnt_dup;
        logic [TIME_W-1:0] last_rx;
        logic [TIME_W-1:0] last_hb;
        logic              hb_seen;
        logic              hb_healthy;
        t_link             mode;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Captured input transaction
    typedef struct packed {
        t_op               op;
        logic [2:0]        session;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] time_ms;
        logic [8:0]        frame_length;
        logic [7:0]        start_byte;
        logic [7:0]        seq;
        logic [1:0]        msg_kind;
        logic              msg_healthy;
    } t_item;

    // Write-back request toward the state memory
    typedef struct packed {
        logic   we;
        t_entry entry;
    } t_wb;

    typedef struct packed {
        logic             accepted;
        logic             slot_opened;
        t_seq_class       seq_class;
        t_link            link_status;
        logic             found;
        logic [CNT_W-1:0] received_count;
        logic [CNT_W-1:0] lost_count;
        logic [CNT_W-1:0] duplicate_count;
        logic [7:0]       last_seq;
        logic             hb_seen;
        logic             hb_ok;
    } t_result;

endpackage

FILE: hw/rtl/lst_ram.sv
module lst_ram import lst_pkg::*; #(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = DEF_SESSION_SLOTS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/lst_update.sv
module lst_update import lst_pkg::*; #(
    parameter int SESSION_SLOTS = DEF_SESSION_SLOTS,
    parameter int MIN_FRAME_LEN = DEF_MIN_FRAME_LEN
) (
    input  t_item            i_item,
    input  logic             i_slot_valid,
    input  t_entry           i_rd_entry,
    input  logic [CFG_W-1:0] i_hb_timeout,
    output t_wb              o_wb,
    output t_result          o_result
);

    t_entry            cur;
    t_entry            upd;
    t_result           res;
    logic              in_range;
    logic              frame_ok;
    logic              key_ok;
    logic              timed_out;
    logic [7:0]        seq_expect;
    logic [7:0]        gap;
    logic [TIME_W-1:0] hb_age;

    // An empty slot reads as cleared, carrying the incoming key
    always_comb begin
        cur = i_slot_valid ? i_rd_entry : '0;
        if (!i_slot_valid) begin
            cur.key = i_item.key;
        end
    end

    // Frame checks, sequence arithmetic and heartbeat age
    always_comb begin
        in_range   = {6'd0, i_item.session} < 9'(SESSION_SLOTS);
        frame_ok   = (i_item.frame_length >= 9'(MIN_FRAME_LEN))
                  && (i_item.start_byte == START_MARK)
                  && ((i_item.msg_kind == KIND_HEARTBEAT) || (i_item.msg_kind == KIND_OTHER));
        key_ok     = (cur.key == i_item.key);
        seq_expect = cur.seq_last + 8'd1;
        gap        = i_item.seq - seq_expect;
        hb_age     = i_item.time_ms - cur.last_hb;
        timed_out  = (cur.last_hb != '0) && (i_item.time_ms > cur.last_hb)
                  && (hb_age > TIME_W'(i_hb_timeout));
    end

    // Modify the slot and build the result
    always_comb begin
        upd      = cur;
        res      = '0;
        o_wb.we  = 1'b0;
        if (in_range) begin
            unique case (i_item.op)
                OP_INGEST: begin
                    if (frame_ok && key_ok) begin
                        o_wb.we         = 1'b1;
                        res.slot_opened = !i_slot_valid;
                        res.found       = 1'b1;
                        if (cur.seq_started && (i_item.seq == cur.seq_last)) begin
                            upd.cnt_dup   = cur.cnt_dup + CNT_W'(1);
                            res.seq_class = SEQ_DUP;
                        end else begin
                            if (!cur.seq_started) begin
                                upd.seq_started = 1'b1;
                                res.seq_class   = SEQ_FIRST;
                            end else if (i_item.seq == seq_expect) begin
                                res.seq_class = SEQ_IN_ORDER;
                            end else begin
                                upd.cnt_lost  = cur.cnt_lost + CNT_W'(gap);
                                upd.mode      = LINK_DEGRADED;
                                res.seq_class = SEQ_GAP;
                            end
                            upd.seq_last = i_item.seq;
                            upd.cnt_rcv  = cur.cnt_rcv + CNT_W'(1);
                            upd.last_rx  = i_item.time_ms;
                            res.accepted = 1'b1;
                            // Heartbeat decides the final link state
                            if (i_item.msg_kind == KIND_HEARTBEAT) begin
                                upd.hb_seen    = 1'b1;
                                upd.hb_healthy = i_item.msg_healthy;
                                upd.last_hb    = i_item.time_ms;
                                upd.mode       = i_item.msg_healthy ? LINK_HEALTHY
                                                                    : LINK_DEGRADED;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (i_slot_valid) begin
                        o_wb.we   = 1'b1;
                        res.found = 1'b1;
                        if (timed_out) begin
                            upd.mode = LINK_LOST;
                        end
                    end
                end
                OP_RECONNECT: begin
                    upd       = '0;
                    upd.key   = i_item.key;
                    upd.mode  = LINK_RECOVERING;
                    o_wb.we   = 1'b1;
                    res.found = 1'b1;
                end
                default: begin
                end
            endcase
        end
        // Snapshot of the updated slot
        if (res.found) begin
            res.link_status     = upd.mode;
            res.received_count  = upd.cnt_rcv;
            res.lost_count      = upd.cnt_lost;
            res.duplicate_count = upd.cnt_dup;
            res.last_seq        = upd.seq_last;
            res.hb_seen         = upd.hb_seen;
            res.hb_ok           = upd.hb_healthy;
        end
        o_wb.entry = upd;
        o_result   = res;
    end

endmodule

FILE: hw/rtl/link_sequence_session_tracker.sv
// Channel   | Handshake                       | Payload
// ----------+---------------------------------+----------------------------------
// command   | start, busy (take: start&!busy) | i_op, i_session, tags, time, frame
// result    | o_done, one-cycle strobe        | o_accepted .. o_hb_ok
// config    | i_cfg_valid, o_cfg_ready        | i_cfg_data (heartbeat timeout, ms)
//
// For each transaction, the accepting edge captures the command and issues the
// state RAM read; in the next cycle (busy high) the slot is modified and
// written back, so the next read of any slot already sees it.
// o_done is high in the cycle after the update cycle; a new command can be taken
// at the same edge at which that result is taken.
// Reset is synchronous; slot valid bits clear at once, so no clearing pass runs.
// The receiver cannot stall; results are never held back.
module link_sequence_session_tracker import lst_pkg::*; #(
    parameter int SESSION_SLOTS = DEF_SESSION_SLOTS,
    parameter int MIN_FRAME_LEN = DEF_MIN_FRAME_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_op,
    input  logic [2:0]       i_session,
    input  logic [15:0]      i_vehicle_tag,
    input  logic [15:0]      i_source_tag,
    input  logic [47:0]      i_time_ms,
    input  logic [8:0]       i_frame_length,
    input  logic [7:0]       i_start_byte,
    input  logic [7:0]       i_sequence_req,
    input  logic [1:0]       i_msg_kind,
    input  logic             i_msg_healthy,
    input  logic [7:0]       i_sysid,
    input  logic [7:0]       i_compid,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_done,
    output logic             o_accepted,
    output logic             o_slot_opened,
    output logic [2:0]       o_seq_class,
    output logic [2:0]       o_link_status,
    output logic             o_found,
    output logic [31:0]      o_received_count,
    output logic [31:0]      o_lost_count,
    output logic [31:0]      o_duplicate_count,
    output logic [7:0]       o_last_seq,
    output logic             o_hb_seen,
    output logic             o_hb_ok
);

    localparam int SLOT_AW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;

    t_state               r_state;
    t_state               n_state;
    t_item                r_item;
    t_item                n_item;
    logic [SESSION_SLOTS-1:0] r_slot_valid;
    logic [CFG_W-1:0]     r_hb_timeout;
    logic                 r_done;
    t_result              r_result;
    logic                 in_accept;
    logic                 ram_we;
    logic [SLOT_AW-1:0]   rd_addr;
    logic [SLOT_AW-1:0]   wr_addr;
    logic [ENTRY_W-1:0]   rd_data;
    t_wb                  wb;
    t_result              upd_result;

    // Capture the command
    always_comb begin
        n_item.op           = t_op'(i_op);
        n_item.session      = i_session;
        n_item.key          = {i_vehicle_tag, i_source_tag, i_sysid, i_compid};
        n_item.time_ms      = i_time_ms;
        n_item.frame_length = i_frame_length;
        n_item.start_byte   = i_start_byte;
        n_item.seq          = i_sequence_req;
        n_item.msg_kind     = i_msg_kind;
        n_item.msg_healthy  = i_msg_healthy;
    end

    assign rd_addr = SLOT_AW'(i_session);
    assign wr_addr = SLOT_AW'(r_item.session);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (start) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        busy        = (r_state == ST_UPDATE);
        o_cfg_ready = (r_state == ST_IDLE);
        in_accept   = start && (r_state == ST_IDLE);
        ram_we      = (r_state == ST_UPDATE) && wb.we;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_valid <= '0;
            r_hb_timeout <= HB_TIMEOUT_RST;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= busy;
            if (ram_we) begin
                r_slot_valid[wr_addr] <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_hb_timeout <= i_cfg_data;
            end
        end
    end

    // Hold the command and the result
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= n_item;
        end
        if (busy) begin
            r_result <= upd_result;
        end
    end

    lst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SESSION_SLOTS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (wb.entry),
        .i_re    (in_accept),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    lst_update #(
        .SESSION_SLOTS (SESSION_SLOTS),
        .MIN_FRAME_LEN (MIN_FRAME_LEN)
    ) u_update (
        .i_item       (r_item),
        .i_slot_valid (r_slot_valid[wr_addr]),
        .i_rd_entry   (t_entry'(rd_data)),
        .i_hb_timeout (r_hb_timeout),
        .o_wb         (wb),
        .o_result     (upd_result)
    );

    // Drive the result ports
    assign o_done            = r_done;
    assign o_accepted        = r_result.accepted;
    assign o_slot_opened     = r_result.slot_opened;
    assign o_seq_class       = r_result.seq_class;
    assign o_link_status     = r_result.link_status;
    assign o_found           = r_result.found;
    assign o_received_count  = r_result.received_count;
    assign o_lost_count      = r_result.lost_count;
    assign o_duplicate_count = r_result.duplicate_count;
    assign o_last_seq        = r_result.last_seq;
    assign o_hb_seen         = r_result.hb_seen;
    assign o_hb_ok           = r_result.hb_ok;

endmodule

FILE: hw/rtl/lst_checker.sv
module lst_checker import lst_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        o_accepted,
    input logic        o_slot_opened,
    input logic [2:0]  o_seq_class,
    input logic [2:0]  o_link_status,
    input logic        o_found,
    input logic [31:0] o_received_count,
    input logic [31:0] o_lost_count,
    input logic [31:0] o_duplicate_count,
    input logic [7:0]  o_last_seq,
    input logic        o_hb_seen,
    input logic        o_hb_ok
);

    // Every accepted transaction passes through the update state and then yields a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_done)
        else $error("no result strobe after an accepted transaction");

    // A result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // A result comes only out of an update cycle
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // A missing snapshot is all zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_found |-> !o_accepted && !o_slot_opened && (o_seq_class == SEQ_NONE)
            && (o_link_status == LINK_UNKNOWN) && (o_received_count == 32'd0)
            && (o_lost_count == 32'd0) && (o_duplicate_count == 32'd0)
            && (o_last_seq == 8'd0) && !o_hb_seen && !o_hb_ok)
        else $error("result without snapshot carries nonzero fields");

    // An accepted frame has a snapshot and a counted sequence class
    a_accept_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_accepted |-> o_found && (o_seq_class != SEQ_NONE)
            && (o_seq_class != SEQ_DUP))
        else $error("accepted frame with no snapshot or an uncounted class");

endmodule

bind link_sequence_session_tracker lst_checker u_lst_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_accepted        (o_accepted),
    .o_slot_opened     (o_slot_opened),
    .o_seq_class       (o_seq_class),
    .o_link_status     (o_link_status),
    .o_found           (o_found),
    .o_received_count  (o_received_count),
    .o_lost_count      (o_lost_count),
    .o_duplicate_count (o_duplicate_count),
    .o_last_seq        (o_last_seq),
    .o_hb_seen         (o_hb_seen),
    .o_hb_ok           (o_hb_ok)
);
